@@ rtl/tli_pkg.sv @@
// Shared types and constants of the table linear interpolator.
package tli_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int NUM_COLUMNS = 4;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(NUM_COLUMNS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CELL_COUNT  = MAX_ROWS * NUM_COLUMNS;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 7;
    localparam int DIV_STEPS   = 33;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [5:0]         row_index;
        logic [1:0]         column_index;
        logic signed [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               out_of_range;
    } t_out_item;

    // One stage of the restoring divider chain.
    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [63:0] num;
        logic [32:0] quo;
    } t_div_stage;

endpackage

@@ rtl/tli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tli_div_cell.sv @@
// One restoring division step; cells are chained to form the divider.
module tli_div_cell import tli_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_den,
    input  t_div_stage  i_stage,
    output t_div_stage  o_stage
);

    t_div_stage  r_stage;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
        trial = {i_stage.rem, i_stage.num[63]};
        diff  = trial - {1'b0, i_den};
        ge    = (trial >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        r_stage.rem <= ge ? diff[31:0] : trial[31:0];
        r_stage.num <= {i_stage.num[62:0], 1'b0};
        r_stage.quo <= {i_stage.quo[31:0], ge};
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/table_linear_interpolator.sv @@
// Top level of the table linear interpolator: table RAM, search sequencer, divider chain.
//
// The block keeps a table of 64 rows by 4 columns of signed Q16.16 values in
// one RAM; column 0 is the x key. A write item stores one cell. A query item
// scans the first rows_in_use rows (capped at 64), one RAM read per cycle,
// looking both for an exact key match (the first one wins) and for the
// interpolation neighbours. A match stops the scan and costs one more read.
// Otherwise four reads fetch x0, x1, y0 and y1, a split 32x33 multiply forms
// (x - x0) * |y1 - y0|, and a chain of 33 divider cells, one quotient bit per
// cell, divides by x1 - x0. The delay of an interpolated result is set by the
// row scan through the single RAM read port and the length of the divider
// chain. A query with no neighbour on one side ends after the scan with
// result 0 and the out-of-range flag. One item is worked on at a time; a
// finished result waits in the output register while the next item is
// taken. rows_in_use may be written only while the block is idle.
module table_linear_interpolator import tli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_RD_MATCH, S_MATCH_W, S_RD_X0, S_RD_X1, S_RD_Y0,
        S_RD_Y1, S_DIFF, S_MUL, S_ADD, S_DIV, S_FIN
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_rows;
    logic signed [31:0] r_x;
    logic [COL_W-1:0]   r_col;
    logic [CFG_W-1:0]   r_idx;
    logic               r_pend;
    logic [ROW_W-1:0]   r_pidx;
    logic               r_lok;
    logic               r_rok;
    logic [ROW_W-1:0]   r_left;
    logic [ROW_W-1:0]   r_right;
    logic [ROW_W-1:0]   r_mrow;
    logic signed [31:0] r_x0;
    logic signed [31:0] r_x1;
    logic signed [31:0] r_y0;
    logic [31:0]        r_dx;
    logic [31:0]        r_den;
    logic [32:0]        r_mag;
    logic               r_neg;
    logic [47:0]        r_plo;
    logic [48:0]        r_phi;
    logic signed [31:0] r_res;
    logic               r_oor;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               accept;
    logic               ram_we;
    logic [ADDR_W-1:0]  raddr;
    logic [DATA_W-1:0]  rdata;
    logic signed [31:0] rd;
    logic [CFG_W-1:0]   rows_eff;
    logic               issue;
    logic signed [32:0] dy;
    logic [64:0]        prod;
    logic [32:0]        quo;
    logic signed [34:0] sum;
    logic signed [31:0] sat;
    t_div_stage         div_in;
    t_div_stage         s_div [DIV_STEPS+1];

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign ram_we      = accept && (i_in_item.operation == OP_WRITE);
    assign o_cfg_ready = 1'b1;
    assign rd          = rdata;

    assign rows_eff = (r_rows > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : r_rows;
    assign issue    = (r_state == S_SCAN) && (r_idx < rows_eff);

    // Read address follows the sequencer state.
    always_comb begin
        case (r_state)
            S_SCAN:     raddr = {r_idx[ROW_W-1:0], COL_W'(0)};
            S_RD_MATCH: raddr = {r_mrow, r_col};
            S_RD_X0:    raddr = {r_left, COL_W'(0)};
            S_RD_X1:    raddr = {r_right, COL_W'(0)};
            S_RD_Y0:    raddr = {r_left, r_col};
            S_RD_Y1:    raddr = {r_right, r_col};
            default:    raddr = '0;
        endcase
    end

    tli_ram #(.WIDTH(DATA_W), .DEPTH(CELL_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({i_in_item.row_index, i_in_item.column_index}),
        .i_wdata (i_in_item.operand_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // The product is below 2^64 and the quotient below 2^33, so the first
    // partial remainder is the product shifted down by 33 bits.
    always_comb begin
        dy           = 33'(rd) - 33'(r_y0);
        prod         = 65'(r_plo) + {r_phi, 16'd0};
        div_in.valid = (r_state == S_ADD);
        div_in.rem   = {1'b0, prod[63:33]};
        div_in.num   = {prod[32:0], 31'd0};
        div_in.quo   = '0;
        quo          = s_div[DIV_STEPS].quo;
        sum          = r_neg ? (35'(r_y0) - 35'(quo)) : (35'(r_y0) + 35'(quo));
        if (sum > 35'sd2147483647) begin
            sat = 32'sh7fffffff;
        end else if (sum < -35'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = sum[31:0];
        end
    end

    assign s_div[0] = div_in;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        tli_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_den   (r_den),
            .i_stage (s_div[g]),
            .o_stage (s_div[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rows <= i_cfg_data;
            end
            // A result loaded in the finish state takes precedence over the drain.
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_in_item.operation == OP_QUERY)) begin
                        r_x     <= i_in_item.operand_value;
                        r_col   <= i_in_item.column_index;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_lok   <= 1'b0;
                        r_rok   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= issue;
                    r_pidx <= r_idx[ROW_W-1:0];
                    r_idx  <= r_idx + CFG_W'(issue);
                    if (r_pend) begin
                        if (rd == r_x) begin
                            r_mrow  <= r_pidx;
                            r_state <= S_RD_MATCH;
                        end else if (!r_rok && (rd < r_x)) begin
                            r_left <= r_pidx;
                            r_lok  <= 1'b1;
                        end else if (!r_rok && (rd > r_x)) begin
                            r_right <= r_pidx;
                            r_rok   <= 1'b1;
                        end
                    end else if (!issue) begin
                        if (r_lok && r_rok) begin
                            r_state <= S_RD_X0;
                        end else begin
                            r_res   <= '0;
                            r_oor   <= 1'b1;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RD_MATCH: r_state <= S_MATCH_W;
                S_MATCH_W: begin
                    r_res   <= rd;
                    r_oor   <= 1'b0;
                    r_state <= S_FIN;
                end
                S_RD_X0: r_state <= S_RD_X1;
                S_RD_X1: begin
                    r_x0    <= rd;
                    r_state <= S_RD_Y0;
                end
                S_RD_Y0: begin
                    r_x1    <= rd;
                    r_state <= S_RD_Y1;
                end
                S_RD_Y1: begin
                    r_y0    <= rd;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    // Here the data port holds y1.
                    r_dx    <= 32'(r_x - r_x0);
                    r_den   <= 32'(r_x1 - r_x0);
                    r_neg   <= dy[32];
                    r_mag   <= dy[32] ? 33'(-dy) : 33'(dy);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_plo   <= 48'(r_dx) * 48'(r_mag[15:0]);
                    r_phi   <= 49'(r_dx) * 49'(r_mag[32:16]);
                    r_state <= S_ADD;
                end
                S_ADD: r_state <= S_DIV;
                S_DIV: begin
                    if (s_div[DIV_STEPS].valid) begin
                        r_res   <= sat;
                        r_oor   <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid             <= 1'b1;
                        r_out_item.result_value <= r_res;
                        r_out_item.out_of_range <= r_oor;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
